// File: hw/rtl/kdpc_pkg.sv
// kdpc_pkg: shared types and constants of the keypad debounce and press classifier
// key masks, special key codes, event codes and configuration register indexes
// no dependencies
package kdpc_pkg;

  localparam int unsigned KEY_COUNT = 5;

  localparam int unsigned CODE_W  = 7;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [KEY_COUNT-1:0] BTN_UP    = 5'h01;
  localparam logic [KEY_COUNT-1:0] BTN_DOWN  = 5'h02;
  localparam logic [KEY_COUNT-1:0] BTN_LEFT  = 5'h04;
  localparam logic [KEY_COUNT-1:0] BTN_RIGHT = 5'h08;
  localparam logic [KEY_COUNT-1:0] BTN_ENTER = 5'h10;

  localparam logic [CODE_W-1:0] CODE_ENTER = 7'h10;
  localparam logic [CODE_W-1:0] CODE_HOME  = 7'h54;

  localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_UP    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DOWN  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_LEFT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_RIGHT = 3'd4;
  localparam logic [EVENT_W-1:0] EV_ENTER = 3'd5;
  localparam logic [EVENT_W-1:0] EV_HOME  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTVL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_REPEATS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_LONG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_WINDOW = 3'd7;

  typedef struct packed {
    logic [CODE_W-1:0]  key_code;
    logic               short_flag;
    logic               repeat_flag;
    logic               long_flag;
    logic [EVENT_W-1:0] event_code;
  } result_t;

endpackage

// File: hw/rtl/keypad_debounce_press_classifier_unit.sv
// keypad_debounce_press_classifier_unit: top level of the keypad press classifier
// debounce, auto-repeat, long press, enter/home handling and a two-entry result queue
// depends on kdpc_pkg
//
// One pin sample per transaction on the input channel gives exactly one result
// transaction. Each sample is classified in the cycle it is accepted: the key
// counters and compares are updated in one pass and the result is written to a
// two-entry output queue (result register plus skid register), so a new sample
// can be taken in every cycle while the skid register is empty, also while one
// result waits on a stalled output. in_stall rises only when both queue entries
// are full. Configuration registers are written through cfg_wr_en / cfg_index /
// cfg_data and take effect on the next sample; write them only while no results
// are pending.
module keypad_debounce_press_classifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kdpc_pkg::KEY_COUNT-1:0] in_raw_pins,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kdpc_pkg::CODE_W-1:0]    out_key_code,
  output logic                           out_short_flag,
  output logic                           out_repeat_flag,
  output logic                           out_long_flag,
  output logic [kdpc_pkg::EVENT_W-1:0]   out_event_code,
  input  logic                           cfg_wr_en,
  input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kdpc_pkg::*;

  // configuration registers
  logic [7:0]  debounce_r;
  logic [14:0] repeat_first_r;
  logic [14:0] repeat_intvl_r;
  logic [3:0]  long_repeats_r;
  logic [15:0] enter_long_r;
  logic [7:0]  release_r;
  logic [7:0]  enter_min_r;
  logic [7:0]  enter_window_r;

  // classifier state
  logic [KEY_COUNT-1:0] prev_keys_r, prev_keys_nxt;
  logic [15:0] hold_cnt_r, hold_cnt_nxt;
  logic [7:0]  repeat_cnt_r, repeat_cnt_nxt;
  logic [15:0] enter_cnt_r, enter_cnt_nxt;
  logic [7:0]  release_cnt_r, release_cnt_nxt;
  logic        lock_r, lock_nxt;

  // output queue
  result_t res_r, res_nxt;
  result_t skid_r, skid_nxt;
  logic    res_vld_r, res_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;

  logic    in_acc;
  logic    out_acc;
  result_t cur;

  logic [KEY_COUNT-1:0] keys;
  logic [15:0] release_inc;
  logic [15:0] enter_inc;
  logic [15:0] hold_inc;
  logic [7:0]  repeat_inc;
  logic [7:0]  repeat_cur;
  logic [15:0] repeat_point;
  logic [8:0]  enter_limit;
  logic [7:0]  release_sat;

  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid & ~skid_vld_r;
  assign out_valid = res_vld_r;
  assign out_acc   = res_vld_r & ~out_stall;

  assign out_key_code    = res_r.key_code;
  assign out_short_flag  = res_r.short_flag;
  assign out_repeat_flag = res_r.repeat_flag;
  assign out_long_flag   = res_r.long_flag;
  assign out_event_code  = res_r.event_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= 8'd3;
      repeat_first_r <= 15'd500;
      repeat_intvl_r <= 15'd10;
      long_repeats_r <= 4'd5;
      enter_long_r   <= 16'd60;
      release_r      <= 8'd3;
      enter_min_r    <= 8'd3;
      enter_window_r <= 8'd30;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:     debounce_r     <= cfg_data[7:0];
        CFG_REPEAT_FIRST: repeat_first_r <= cfg_data[14:0];
        CFG_REPEAT_INTVL: repeat_intvl_r <= cfg_data[14:0];
        CFG_LONG_REPEATS: long_repeats_r <= cfg_data[3:0];
        CFG_ENTER_LONG:   enter_long_r   <= cfg_data;
        CFG_RELEASE:      release_r      <= cfg_data[7:0];
        CFG_ENTER_MIN:    enter_min_r    <= cfg_data[7:0];
        CFG_ENTER_WINDOW: enter_window_r <= cfg_data[7:0];
      endcase
    end
  end

  // classification of one sample
  always_comb begin
    keys = ~in_raw_pins;

    prev_keys_nxt   = keys;
    hold_cnt_nxt    = hold_cnt_r;
    repeat_cnt_nxt  = repeat_cnt_r;
    enter_cnt_nxt   = enter_cnt_r;
    release_cnt_nxt = release_cnt_r;
    lock_nxt        = lock_r;

    cur = '0;

    release_sat  = (release_cnt_r != 8'hFF) ? release_cnt_r + 8'd1 : 8'hFF;
    release_inc  = {8'd0, release_sat};
    enter_inc    = (enter_cnt_r != 16'hFFFF) ? enter_cnt_r + 16'd1 : 16'hFFFF;
    hold_inc     = (hold_cnt_r != 16'hFFFF) ? hold_cnt_r + 16'd1 : 16'hFFFF;
    repeat_inc   = (repeat_cnt_r != 8'hFF) ? repeat_cnt_r + 8'd1 : 8'hFF;
    repeat_point = {1'b0, repeat_first_r} + {1'b0, repeat_intvl_r};
    enter_limit  = {1'b0, enter_min_r} + {1'b0, enter_window_r};
    repeat_cur   = repeat_cnt_r;

    // enter / home path and release lock
    if (lock_r) begin
      if (keys == '0) begin
        if (release_inc >= {8'd0, release_r}) begin
          release_cnt_nxt = '0;
          lock_nxt        = 1'b0;
        end else begin
          release_cnt_nxt = release_sat;
        end
      end else begin
        release_cnt_nxt = '0;
      end
    end else if (keys == BTN_ENTER) begin
      if (enter_inc >= enter_long_r) begin
        enter_cnt_nxt = '0;
        cur.key_code  = CODE_HOME;
        cur.long_flag = 1'b1;
        lock_nxt      = 1'b1;
      end else begin
        enter_cnt_nxt = enter_inc;
      end
    end else begin
      if (enter_cnt_r >= {8'd0, enter_min_r} && enter_cnt_r < {7'd0, enter_limit}) begin
        cur.key_code   = CODE_ENTER;
        cur.short_flag = 1'b1;
      end
      enter_cnt_nxt = '0;
    end

    // normal debounce path, runs also while locked
    if (keys == '0 || keys != prev_keys_r || keys == BTN_ENTER) begin
      hold_cnt_nxt   = '0;
      repeat_cnt_nxt = '0;
    end else begin
      hold_cnt_nxt = hold_inc;
      if (hold_inc == {8'd0, debounce_r}) begin
        cur.key_code   = {2'b00, keys};
        cur.short_flag = 1'b1;
      end
      if (hold_inc == repeat_point) begin
        cur.key_code    = {2'b00, keys};
        cur.repeat_flag = 1'b1;
        hold_cnt_nxt    = {1'b0, repeat_first_r};
        repeat_cur      = repeat_inc;
      end
      repeat_cnt_nxt = repeat_cur;
      if (repeat_cur == {4'd0, long_repeats_r}) begin
        cur.key_code   = {2'b00, keys};
        cur.long_flag  = 1'b1;
        repeat_cnt_nxt = {3'd0, {1'b0, long_repeats_r} + 5'd1};
      end
    end

    // event mapping, later matches win
    if (cur.key_code != '0) begin
      if (cur.short_flag && cur.key_code == {2'b00, BTN_UP})    cur.event_code = EV_UP;
      if (cur.short_flag && cur.key_code == {2'b00, BTN_DOWN})  cur.event_code = EV_DOWN;
      if (cur.short_flag && cur.key_code == {2'b00, BTN_LEFT})  cur.event_code = EV_LEFT;
      if (cur.short_flag && cur.key_code == {2'b00, BTN_RIGHT}) cur.event_code = EV_RIGHT;
      if (cur.key_code == CODE_ENTER) cur.event_code = EV_ENTER;
      if (cur.key_code == CODE_HOME)  cur.event_code = EV_HOME;
    end else begin
      cur.event_code = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r   <= '0;
      hold_cnt_r    <= '0;
      repeat_cnt_r  <= '0;
      enter_cnt_r   <= '0;
      release_cnt_r <= '0;
      lock_r        <= 1'b0;
    end else if (in_acc) begin
      prev_keys_r   <= prev_keys_nxt;
      hold_cnt_r    <= hold_cnt_nxt;
      repeat_cnt_r  <= repeat_cnt_nxt;
      enter_cnt_r   <= enter_cnt_nxt;
      release_cnt_r <= release_cnt_nxt;
      lock_r        <= lock_nxt;
    end
  end

  // result queue: skid entry fills only while the result register is held
  always_comb begin
    res_nxt      = res_r;
    skid_nxt     = skid_r;
    res_vld_nxt  = res_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_acc) begin
      if (skid_vld_r) begin
        res_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        res_nxt     = cur;
        res_vld_nxt = in_acc;
      end
    end else if (in_acc) begin
      if (!res_vld_r) begin
        res_nxt     = cur;
        res_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = cur;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      res_vld_r  <= res_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    skid_r <= skid_nxt;
  end

endmodule
